### src/bblur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants of the 3x3 box blur
// Payload structs, controller/datapath command and status groups,
// register codes and the reciprocal table for the mean division.
// ----------------------------------------------------------------------------
package bblur_pkg;

  // Field widths fixed by the pixel format and the register map.
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int ROW_W      = FH_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIN_N      = 9;

  // A sum of nine 8-bit values and a count of 1 to 9.
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;

  // Reciprocal multiply: floor(s / n) == (s * ceil(2^16 / n)) >> 16 for s < 2^12.
  localparam int RECIP_SH   = 16;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int PROD_W     = SUM_W + RECIP_W;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Item commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Reset register values.
  localparam int RST_FRAME_WIDTH  = 640;
  localparam int RST_FRAME_HEIGHT = 480;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            frame_end;
  } pix_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted item
    logic rd;    // read both line stores, latch the result's mask
    logic sum;   // add up the masked window
    logic wr;    // shift the window, write line stores, step counters
    logic div;   // divide and load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_frame;
    logic pend_zero;
    logic pre_res;
    logic post_res;
    logic out_free;
  } dp_stat_t;

  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

### src/bblur_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_ctrl: sequencer of the 3x3 box blur
// Accepts or drops items, then steps the datapath through read and write,
// with sum and divide when a result is due, for each window advance.
// ----------------------------------------------------------------------------
module bblur_ctrl
  import bblur_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_stall,
  output logic     cfg_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SUM_PRE,
    ST_WR,
    ST_SUM_POST,
    ST_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   pre_r, pre_nxt;
  logic   post_r, post_nxt;
  logic   second_r, second_nxt;
  logic   take_pix, take_drain;

  // A pixel is taken inside the frame; a drain tick only while results are owed.
  assign take_pix   = in_valid && (in_cmd == CMD_PIXEL) && stat.in_frame;
  assign take_drain = in_valid && (in_cmd == CMD_DRAIN) && !stat.in_frame &&
                      !stat.pend_zero;

  // Next state logic.
  always_comb begin
    state_nxt  = state_r;
    pre_nxt    = pre_r;
    post_nxt   = post_r;
    second_nxt = second_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take_pix || take_drain) begin
          state_nxt  = ST_RD;
          second_nxt = take_drain;
        end
      end
      ST_RD: begin
        pre_nxt   = stat.pre_res;
        post_nxt  = stat.post_res;
        state_nxt = stat.pre_res ? ST_SUM_PRE : ST_WR;
      end
      ST_SUM_PRE: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (post_r) begin
          state_nxt = ST_SUM_POST;
        end else if (pre_r) begin
          state_nxt = ST_DIV;
        end else if (second_r) begin
          // A drain tick that gave nothing advances once more.
          second_nxt = 1'b0;
          state_nxt  = ST_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM_POST: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pre_r    <= 1'b0;
      post_r   <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pre_r    <= pre_nxt;
      post_r   <= post_nxt;
      second_r <= second_nxt;
    end
  end

  // Handshake and datapath commands decoded from the state.
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.load = (state_r == ST_IDLE) && in_valid;
    cmd.rd   = (state_r == ST_RD);
    cmd.sum  = (state_r == ST_SUM_PRE) || (state_r == ST_SUM_POST);
    cmd.wr   = (state_r == ST_WR);
    cmd.div  = (state_r == ST_DIV) && stat.out_free;
  end

  // The sum before the window shift only serves a result at the start of a row.
  a_sum_pre_only_for_pre: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM_PRE) |-> pre_r)
    else $error("pre-shift sum without a pending row-start result");

  // A second advance is only tried by a drain tick.
  a_second_is_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && take_pix) |=> !second_r)
    else $error("pixel transaction armed a second advance");

  // At most one result per advance.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |-> !(pre_r && post_r))
    else $error("two results from one advance");

endmodule

### src/bblur_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_dp: datapath of the 3x3 box blur
// Two line stores, the 3x3 window, raster counters, the masked window
// sum, the reciprocal division and the output register.
// ----------------------------------------------------------------------------
module bblur_dp
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  pix_in_t               in_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_out_t              out_data
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int RST_W = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;

  // Line stores: row_a holds the previous row, row_b the one before it.
  logic [PIX_W-1:0] row_a [MAX_WIDTH];
  logic [PIX_W-1:0] row_b [MAX_WIDTH];
  logic [PIX_W-1:0] rd_a_r, rd_b_r;

  logic [PIX_W-1:0] win_r [WIN_N];

  logic [WW-1:0]    eff_w_r, eff_w_nxt;
  logic [FH_W-1:0]  eff_h_r, eff_h_nxt;
  logic [AW-1:0]    cx_r, cx_nxt;
  logic [ROW_W-1:0] cy_r, cy_nxt;
  logic [PW-1:0]    pend_r, pend_nxt, pend_inc;

  logic [PIX_W-1:0] pix_r;
  logic             real_r;
  logic [WIN_N-1:0] mask_r, mask_nxt;
  logic             last_r, last_nxt;
  logic             got_r;

  logic [SUM_W-1:0] sb_r, sg_r, sr_r, sb_nxt, sg_nxt, sr_nxt;
  logic [CNT_W-1:0] n_r;
  logic [PROD_W-1:0] prod_blue, prod_green, prod_red;

  logic             out_valid_r;
  pix_out_t         out_data_r;

  logic             cfg_hit;
  logic [FW_W-1:0]  cfg_w;
  logic [ROW_W-1:0] h_ext;
  logic [WW:0]      cx_inc;
  logic             wrap;
  logic [2:0]       row_m, col_m;

  assign h_ext = ROW_W'(eff_h_r);

  // Status for the controller.
  assign stat.in_frame  = cy_r < h_ext;
  assign stat.pend_zero = (pend_r == '0);
  assign stat.pre_res   = (cx_r == '0) && (cy_r >= ROW_W'(2));
  assign stat.post_res  = (cx_r != '0) && (cy_r >= ROW_W'(1));
  assign stat.out_free  = !out_valid_r || !out_stall;

  // Register writes: clamp the width to 1..MAX_WIDTH and the height to at least 1.
  assign cfg_w = cfg_data[FW_W-1:0];

  always_comb begin
    cfg_hit   = 1'b0;
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          cfg_hit = 1'b1;
          if (cfg_w == '0) begin
            eff_w_nxt = WW'(1);
          end else if (int'(cfg_w) > MAX_WIDTH) begin
            eff_w_nxt = WW'(MAX_WIDTH);
          end else begin
            eff_w_nxt = WW'(cfg_w);
          end
        end
        REG_FRAME_HEIGHT: begin
          cfg_hit   = 1'b1;
          eff_h_nxt = (cfg_data == '0) ? FH_W'(1) : cfg_data;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // Mask of the window cells that the pending result covers. A result at the
  // start of a row is for the last pixel two rows up, taken before the shift;
  // any other result is for the pixel one row up and one column left, after it.
  always_comb begin
    if (stat.pre_res) begin
      row_m    = {cy_r <= h_ext, 1'b1, cy_r >= ROW_W'(3)};
      col_m    = {1'b1, eff_w_r >= WW'(2), 1'b0};
      last_nxt = (cy_r == h_ext + ROW_W'(1));
    end else begin
      row_m    = {cy_r < h_ext, 1'b1, cy_r >= ROW_W'(2)};
      col_m    = {1'b1, 1'b1, cx_r >= AW'(2)};
      // The column left of the current one is never the last of the row.
      last_nxt = 1'b0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask_nxt[r*3+c] = row_m[r] && col_m[c];
      end
    end
  end

  // Raster counters and the count of owed results.
  assign cx_inc   = (WW+1)'(cx_r) + (WW+1)'(1);
  assign wrap     = cx_inc >= (WW+1)'(eff_w_r);
  assign pend_inc = real_r ? pend_r + PW'(1) : pend_r;

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    pend_nxt = pend_r;
    if (cfg_hit) begin
      cx_nxt   = '0;
      cy_nxt   = '0;
      pend_nxt = '0;
    end else if (cmd.wr) begin
      cx_nxt   = wrap ? '0 : AW'(cx_inc);
      cy_nxt   = wrap ? cy_r + ROW_W'(1) : cy_r;
      pend_nxt = (got_r && pend_inc != '0) ? pend_inc - PW'(1) : pend_inc;
      if (got_r && last_r) begin
        cx_nxt   = '0;
        cy_nxt   = '0;
        pend_nxt = '0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r     <= WW'(RST_W);
      eff_h_r     <= FH_W'(RST_FRAME_HEIGHT);
      cx_r        <= '0;
      cy_r        <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      pend_r  <= pend_nxt;
      if (cmd.div) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Line stores: one read and one write port each, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_a_r <= row_a[cx_r];
      rd_b_r <= row_b[cx_r];
    end
    if (cmd.wr) begin
      row_a[cx_r] <= pix_r;
      row_b[cx_r] <= rd_a_r;
    end
  end

  // Captured item and the description of the pending result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r  <= (in_data.cmd == CMD_DRAIN) ? '0 :
                {in_data.in_red, in_data.in_green, in_data.in_blue};
      real_r <= (in_data.cmd == CMD_PIXEL);
    end
    if (cmd.rd) begin
      mask_r <= mask_nxt;
      last_r <= last_nxt;
      got_r  <= stat.pre_res || stat.post_res;
    end
  end

  // Window shift: columns move left, the new column comes from the stores and the captured pixel.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3+0] <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= rd_b_r;
      win_r[5] <= rd_a_r;
      win_r[8] <= pix_r;
    end
  end

  // Masked window sum per channel.
  always_comb begin
    sb_nxt = '0;
    sg_nxt = '0;
    sr_nxt = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (mask_r[i]) begin
        sb_nxt = sb_nxt + SUM_W'(win_r[i][CH_W-1:0]);
        sg_nxt = sg_nxt + SUM_W'(win_r[i][2*CH_W-1:CH_W]);
        sr_nxt = sr_nxt + SUM_W'(win_r[i][3*CH_W-1:2*CH_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sb_r <= sb_nxt;
      sg_r <= sg_nxt;
      sr_r <= sr_nxt;
      n_r  <= CNT_W'($countones(mask_r));
    end
  end

  // Mean by reciprocal multiply; exact for sums below 2^12 and counts 1 to 9.
  assign prod_blue  = PROD_W'(sb_r) * PROD_W'(recip_of(n_r));
  assign prod_green = PROD_W'(sg_r) * PROD_W'(recip_of(n_r));
  assign prod_red   = PROD_W'(sr_r) * PROD_W'(recip_of(n_r));

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      out_data_r.out_blue  <= prod_blue[RECIP_SH +: CH_W];
      out_data_r.out_green <= prod_green[RECIP_SH +: CH_W];
      out_data_r.out_red   <= prod_red[RECIP_SH +: CH_W];
      out_data_r.frame_end <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The column counter stays inside the row.
  a_cx_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(cx_r) < eff_w_r)
    else $error("column counter beyond frame width");

  // Owed results never exceed one row plus one pixel.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (PW+1)'(pend_r) <= (PW+1)'(eff_w_r) + (PW+1)'(1))
    else $error("owed result count beyond one row plus one");

  // A result is loaded only into a free output register.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a waiting transaction");

  // The last result of a frame rearms the block for a new frame.
  a_frame_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr && got_r && last_r) |=> (cy_r == '0 && pend_r == '0 && cx_r == '0))
    else $error("counters not cleared after the frame's last result");

endmodule

### src/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb: 3x3 mean filter over a raster stream of BGR pixels
// Each result is the truncated per-channel mean over the in-frame part of
// the pixel's 3x3 neighborhood; results trail the input by a row and a pixel.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  pix_in_t   (cmd, blue, green, red)
//  out_     output     out_valid/out_stall  pix_out_t  (blue, green, red, frame_end)
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A dropped item leaves the sequencer idle. An advance without a result runs the
//  line store read, then the store write and shift; one with a result adds the
//  window sum and the reciprocal divide, which waits for a free output register.
//  A drain tick that gives nothing advances twice; in_stall holds items until idle.
//  Reset clears the raster counters and the owed count and loads width 640 and
//  height 480; line store contents are not cleared and need no clearing pass.
//  A result waits in the output register while out_stall is high; a finished
//  result may wait there while the next item is accepted and processed.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  // A register write completes on valid and ready.
  assign cfg_we = cfg_valid && cfg_ready;

  bblur_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bblur_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
